FILE: sv/pco_pkg.sv
// ---------------------------------------------------------------------------
// pco_pkg: shared types, constants and functions of the cursor overlay
// Sizes, sprite codes, report result bundle, clamp limits and arrow bitmap.
// ---------------------------------------------------------------------------
`default_nettype none

package pco_pkg;

    // Coordinate and field widths
    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int DELTA_BITS = 16;
    localparam int COLOR_BITS = 32;
    localparam int SUM_BITS   = ((COORD_BITS > DELTA_BITS) ? COORD_BITS : DELTA_BITS) + 2;

    // Largest usable screen size in pixels
    localparam int SCREEN_LIM = 1 << COORD_BITS;

    // Register indexes and reset values
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(768);

    // Item kinds
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Arrow sprite geometry and colors
    localparam int SPRITE_W  = 15;
    localparam int SPRITE_H  = 23;
    localparam int ROW_BITS  = $clog2(SPRITE_H);
    localparam int COL_BITS  = $clog2(SPRITE_W);
    localparam int TIP_LAST  = 13;   // last row of the widening triangle
    localparam int BAR_ROW   = 14;   // horizontal base of the arrow
    localparam int BAR_BLACK = 5;    // last black column on the base row
    localparam int TAIL_LAST = 20;   // last row that draws anything
    localparam logic [COLOR_BITS-1:0] WHITE_ARGB = 32'hFFFF_FFFF;
    localparam logic [COLOR_BITS-1:0] BLACK_ARGB = 32'hFF00_0000;

    typedef enum logic [1:0] {
        SPR_CLEAR = 2'd0,
        SPR_WHITE = 2'd1,
        SPR_BLACK = 2'd2
    } sprite_code_t;

    // Result fields of a mouse report
    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  pressed;
        logic                  released;
        logic                  moved;
        logic [1:0]            mask;
    } report_t;

    // Screen size register value to largest valid coordinate
    function automatic logic [COORD_BITS-1:0] size_to_max(input logic [CFG_BITS-1:0] size);
        logic [COORD_BITS-1:0] lim;
        lim = '0;
        if (size == '0) begin
            lim = '0;
        end else if (int'(size) > SCREEN_LIM) begin
            lim = '1;
        end else begin
            lim = COORD_BITS'(size - 1'b1);
        end
        return lim;
    endfunction

    // Arrow bitmap: outline white, body black, base row closes the triangle
    function automatic sprite_code_t arrow_code(input logic [ROW_BITS-1:0] row,
                                                input logic [COL_BITS-1:0] col);
        sprite_code_t          code;
        logic [ROW_BITS-1:0]   rim;
        logic [ROW_BITS-1:0]   col_w;
        code  = SPR_CLEAR;
        rim   = '0;
        col_w = ROW_BITS'(col);
        if (int'(row) <= TIP_LAST) begin
            rim = row;
        end else if (int'(row) > BAR_ROW && int'(row) <= TAIL_LAST) begin
            rim = ROW_BITS'(TAIL_LAST) - row;
        end
        if (int'(row) == BAR_ROW) begin
            if (col == '0) begin
                code = SPR_WHITE;
            end else if (int'(col) <= BAR_BLACK) begin
                code = SPR_BLACK;
            end else if (int'(col) < SPRITE_W) begin
                code = SPR_WHITE;
            end
        end else if (int'(row) <= TAIL_LAST) begin
            if (col == '0 || col_w == rim) begin
                code = SPR_WHITE;
            end else if (col_w < rim) begin
                code = SPR_BLACK;
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pco_motion.sv
// ---------------------------------------------------------------------------
// pco_motion: mouse report datapath
// Adds signed deltas to the cursor, clamps to the screen, finds button edges.
// ---------------------------------------------------------------------------
`default_nettype none

module pco_motion (
    input  wire logic [pco_pkg::COORD_BITS-1:0]        pos_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0]        pos_y,
    input  wire logic                                  last_left,
    input  wire logic [pco_pkg::COORD_BITS-1:0]        max_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0]        max_y,
    input  wire logic signed [pco_pkg::DELTA_BITS-1:0] delta_x,
    input  wire logic signed [pco_pkg::DELTA_BITS-1:0] delta_y,
    input  wire logic                                  left_button,
    input  wire logic                                  right_button,
    output pco_pkg::report_t                           report
);

    localparam int SB = pco_pkg::SUM_BITS;
    localparam int CB = pco_pkg::COORD_BITS;
    localparam int DB = pco_pkg::DELTA_BITS;

    logic [SB-1:0] sum_x;
    logic [SB-1:0] sum_y;
    logic [CB-1:0] new_x;
    logic [CB-1:0] new_y;

    // Sign-extended add of delta to position
    assign sum_x = {{(SB-CB){1'b0}}, pos_x} + {{(SB-DB){delta_x[DB-1]}}, delta_x};
    assign sum_y = {{(SB-CB){1'b0}}, pos_y} + {{(SB-DB){delta_y[DB-1]}}, delta_y};

    // Clamp to 0..max
    always_comb begin
        priority if (sum_x[SB-1]) begin
            new_x = '0;
        end else if (sum_x > {{(SB-CB){1'b0}}, max_x}) begin
            new_x = max_x;
        end else begin
            new_x = sum_x[CB-1:0];
        end
        priority if (sum_y[SB-1]) begin
            new_y = '0;
        end else if (sum_y > {{(SB-CB){1'b0}}, max_y}) begin
            new_y = max_y;
        end else begin
            new_y = sum_y[CB-1:0];
        end
    end

    // Result bundle
    always_comb begin
        report.pos_x    = new_x;
        report.pos_y    = new_y;
        report.pressed  = left_button & ~last_left;
        report.released = ~left_button & last_left;
        report.moved    = (delta_x != '0) | (delta_y != '0);
        report.mask     = {right_button, left_button};
    end

endmodule

`default_nettype wire

FILE: sv/pco_sprite.sv
// ---------------------------------------------------------------------------
// pco_sprite: pixel query datapath
// Looks up the arrow sprite at the pixel's offset from the cursor.
// ---------------------------------------------------------------------------
`default_nettype none

module pco_sprite (
    input  wire logic [pco_pkg::COORD_BITS-1:0] pos_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0] pos_y,
    input  wire logic [pco_pkg::COORD_BITS-1:0] max_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0] max_y,
    input  wire logic [pco_pkg::COORD_BITS-1:0] pixel_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0] pixel_y,
    input  wire logic [pco_pkg::COLOR_BITS-1:0] under_color,
    output logic      [pco_pkg::COLOR_BITS-1:0] pixel_color
);

    localparam int CB = pco_pkg::COORD_BITS;

    logic [CB-1:0]         col_off;
    logic [CB-1:0]         row_off;
    logic                  hit;
    pco_pkg::sprite_code_t code;

    // Offset from cursor hot spot and sprite window test
    assign col_off = pixel_x - pos_x;
    assign row_off = pixel_y - pos_y;
    assign hit = (pixel_x <= max_x) && (pixel_y <= max_y)
              && (pixel_x >= pos_x) && (pixel_y >= pos_y)
              && (col_off < CB'(pco_pkg::SPRITE_W))
              && (row_off < CB'(pco_pkg::SPRITE_H));

    assign code = pco_pkg::arrow_code(row_off[pco_pkg::ROW_BITS-1:0],
                                      col_off[pco_pkg::COL_BITS-1:0]);

    // Overlay: opaque sprite pixels replace the underlying color
    always_comb begin
        pixel_color = under_color;
        if (hit) begin
            unique case (code)
                pco_pkg::SPR_WHITE: pixel_color = pco_pkg::WHITE_ARGB;
                pco_pkg::SPR_BLACK: pixel_color = pco_pkg::BLACK_ARGB;
                default:            pixel_color = under_color;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/pointer_cursor_overlay.sv
// An accepted item passes through the input register and then the result register.
// One item per cycle while results are taken; the cursor state updates as an item leaves the
// input register, so the next item already sees the new position.
// A stalled result holds; the input register still takes an item when the result moves.
// Reset (aresetn low, synchronous): both stages empty, cursor at 0,0, left button
// released, screen 1024 x 768.
// ---------------------------------------------------------------------------
// pointer_cursor_overlay: hardware mouse cursor with arrow sprite overlay
// Mouse reports move the clamped cursor; pixel queries overlay the arrow sprite.
// ---------------------------------------------------------------------------
`default_nettype none

module pointer_cursor_overlay (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire logic                                  cfg_index,
    input  wire logic [pco_pkg::CFG_BITS-1:0]          cfg_wdata,
    // input items
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_cmd,
    input  wire logic signed [pco_pkg::DELTA_BITS-1:0] s_delta_x,
    input  wire logic signed [pco_pkg::DELTA_BITS-1:0] s_delta_y,
    input  wire logic                                  s_left_button,
    input  wire logic                                  s_right_button,
    input  wire logic [pco_pkg::COORD_BITS-1:0]        s_pixel_x,
    input  wire logic [pco_pkg::COORD_BITS-1:0]        s_pixel_y,
    input  wire logic [pco_pkg::COLOR_BITS-1:0]        s_under_color,
    // result items
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [pco_pkg::COORD_BITS-1:0]             m_cursor_x,
    output logic [pco_pkg::COORD_BITS-1:0]             m_cursor_y,
    output logic                                       m_left_pressed_edge,
    output logic                                       m_left_released_edge,
    output logic                                       m_moved,
    output logic [1:0]                                 m_button_mask,
    output logic [pco_pkg::COLOR_BITS-1:0]             m_pixel_color
);

    localparam int CB = pco_pkg::COORD_BITS;

    // Configuration, kept as largest valid coordinate
    logic [CB-1:0] max_x_reg;
    logic [CB-1:0] max_y_reg;

    // Cursor state
    logic [CB-1:0] pos_x_reg;
    logic [CB-1:0] pos_y_reg;
    logic          last_left_reg;

    // Input register
    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic                                  in_cmd_reg;
    logic signed [pco_pkg::DELTA_BITS-1:0] in_dx_reg;
    logic signed [pco_pkg::DELTA_BITS-1:0] in_dy_reg;
    logic                                  in_left_reg;
    logic                                  in_right_reg;
    logic [CB-1:0]                         in_px_reg;
    logic [CB-1:0]                         in_py_reg;
    logic [pco_pkg::COLOR_BITS-1:0]        in_color_reg;

    // Result register
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [CB-1:0]                         out_x_reg;
    logic [CB-1:0]                         out_y_reg;
    logic                                  out_pressed_reg;
    logic                                  out_released_reg;
    logic                                  out_moved_reg;
    logic [1:0]                            out_mask_reg;
    logic [pco_pkg::COLOR_BITS-1:0]        out_color_reg;

    logic                           out_free;
    logic                           advance;
    logic                           take;
    logic                           is_report;
    pco_pkg::report_t               report;
    logic [pco_pkg::COLOR_BITS-1:0] query_color;

    // Handshake: result stage frees up when empty or being taken
    assign out_free  = ~out_valid_reg | m_ready;
    assign advance   = in_valid_reg & out_free;
    assign s_ready   = ~in_valid_reg | out_free;
    assign take      = s_valid & s_ready;
    assign is_report = (in_cmd_reg == pco_pkg::CMD_REPORT);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Datapaths
    pco_motion u_motion (
        .pos_x        (pos_x_reg),
        .pos_y        (pos_y_reg),
        .last_left    (last_left_reg),
        .max_x        (max_x_reg),
        .max_y        (max_y_reg),
        .delta_x      (in_dx_reg),
        .delta_y      (in_dy_reg),
        .left_button  (in_left_reg),
        .right_button (in_right_reg),
        .report       (report)
    );

    pco_sprite u_sprite (
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .max_x       (max_x_reg),
        .max_y       (max_y_reg),
        .pixel_x     (in_px_reg),
        .pixel_y     (in_py_reg),
        .under_color (in_color_reg),
        .pixel_color (query_color)
    );

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            last_left_reg <= 1'b0;
            max_x_reg     <= pco_pkg::size_to_max(pco_pkg::WIDTH_RESET);
            max_y_reg     <= pco_pkg::size_to_max(pco_pkg::HEIGHT_RESET);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance && is_report) begin
                pos_x_reg     <= report.pos_x;
                pos_y_reg     <= report.pos_y;
                last_left_reg <= in_left_reg;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    pco_pkg::REG_SCREEN_WIDTH:  max_x_reg <= pco_pkg::size_to_max(cfg_wdata);
                    pco_pkg::REG_SCREEN_HEIGHT: max_y_reg <= pco_pkg::size_to_max(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // Input payload register
    always_ff @(posedge aclk) begin
        if (take) begin
            in_cmd_reg   <= s_cmd;
            in_dx_reg    <= s_delta_x;
            in_dy_reg    <= s_delta_y;
            in_left_reg  <= s_left_button;
            in_right_reg <= s_right_button;
            in_px_reg    <= s_pixel_x;
            in_py_reg    <= s_pixel_y;
            in_color_reg <= s_under_color;
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (is_report) begin
                out_x_reg        <= report.pos_x;
                out_y_reg        <= report.pos_y;
                out_pressed_reg  <= report.pressed;
                out_released_reg <= report.released;
                out_moved_reg    <= report.moved;
                out_mask_reg     <= report.mask;
                out_color_reg    <= '0;
            end else begin
                out_x_reg        <= pos_x_reg;
                out_y_reg        <= pos_y_reg;
                out_pressed_reg  <= 1'b0;
                out_released_reg <= 1'b0;
                out_moved_reg    <= 1'b0;
                out_mask_reg     <= '0;
                out_color_reg    <= query_color;
            end
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_cursor_x           = out_x_reg;
    assign m_cursor_y           = out_y_reg;
    assign m_left_pressed_edge  = out_pressed_reg;
    assign m_left_released_edge = out_released_reg;
    assign m_moved              = out_moved_reg;
    assign m_button_mask        = out_mask_reg;
    assign m_pixel_color        = out_color_reg;

endmodule

`default_nettype wire

FILE: sv/pco_checker.sv
// ---------------------------------------------------------------------------
// pco_checker: port-level checks for the cursor overlay
// Watches the result channel; attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module pco_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic                              m_left_pressed_edge,
    input wire logic                              m_left_released_edge,
    input wire logic [1:0]                        m_button_mask,
    input wire logic [pco_pkg::COORD_BITS-1:0]    m_cursor_x,
    input wire logic [pco_pkg::COLOR_BITS-1:0]    m_pixel_color
);

    // Nothing comes out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_x) && $stable(m_pixel_color))
        else $error("stalled result changed");

    // Press and release cannot both happen in one report
    a_edge_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_left_pressed_edge && m_left_released_edge))
        else $error("press and release in one item");

    // Edges agree with the reported left button
    a_edge_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_left_pressed_edge || m_left_released_edge)
            |-> (m_button_mask[0] == m_left_pressed_edge))
        else $error("button edge disagrees with button mask");

endmodule

bind pointer_cursor_overlay pco_checker u_pco_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_left_pressed_edge  (m_left_pressed_edge),
    .m_left_released_edge (m_left_released_edge),
    .m_button_mask        (m_button_mask),
    .m_cursor_x           (m_cursor_x),
    .m_pixel_color        (m_pixel_color)
);

`default_nettype wire
